// File: rtl/fcce_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the allocation table engine.
// Used by fcce_core, fat_cluster_chain_engine, fcce_checker and tb_top; depends on nothing.
package fcce_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int LINK_W = 12;
  localparam int ANS_W = LINK_W + 1;
  localparam int KIND_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W = 12;

  localparam logic [LINK_W-1:0] RESERVED_LINK_FLOOR = 12'hFF0;
  localparam logic [LINK_W-1:0] DATA_START_RESET = 12'd14;
  localparam logic [LINK_W-1:0] END_MARKER_RESET = 12'hFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIND_FREE    = 3'd0,
    KIND_COUNT_FREE   = 3'd1,
    KIND_WRITE_ENTRY  = 3'd2,
    KIND_FOLLOW_LINKS = 3'd3,
    KIND_CHAIN_LENGTH = 3'd4,
    KIND_FREE_CHAIN   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINK_W-1:0] entry_index;
    logic [LINK_W-1:0] operand;
  } req_t;

  typedef struct packed {
    logic [LINK_W-1:0] data_start_entry;
    logic [LINK_W-1:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic [ANS_W-1:0] answer;
    logic             found;
  } res_t;

  function automatic logic link_continues(input logic [LINK_W-1:0] v,
                                          input logic [LINK_W-1:0] end_marker);
    link_continues = !((v == end_marker) || (v == '0) || (v >= RESERVED_LINK_FLOOR));
  endfunction

  function automatic logic in_table(input logic [LINK_W-1:0] v);
    in_table = ({1'b0, v} < ANS_W'(TABLE_ENTRIES));
  endfunction

endpackage

// File: rtl/fat_cluster_chain_engine.sv
`timescale 1ns / 1ps
// Top level of the allocation table engine: configuration registers, input
// handshake and output word register around fcce_core. Depends on fcce_pkg.
//
// An input word (kind, entry_index, operand) is taken when in_valid is high
// and in_stall is low; exactly one output word (answer, found) follows on the
// out channel, taken when out_valid is high and out_stall is low.
// After reset the engine clears all 4096 table entries, one per cycle, and
// holds in_stall high while it does so; configuration writes are taken
// at any time and the registers return to 14 and 4095.
// The table is a single-port memory with a registered read:
// a write or an immediate answer needs no table read, a free search
// or free count scans upward from data_start_entry, one entry per
// cycle, and chain walks read each link, then decode it.
// One word is worked on at a time. A finished word waits in the output
// register while the next input word is already being processed; if the
// receiver keeps stalling, the engine holds its next result and stops there.
module fat_cluster_chain_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [fcce_pkg::KIND_W-1:0]          kind,
  input  logic [fcce_pkg::LINK_W-1:0]          entry_index,
  input  logic [fcce_pkg::LINK_W-1:0]          operand,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [fcce_pkg::ANS_W-1:0]           answer,
  output logic                                 found,
  input  logic                                 cfg_write,
  input  logic [fcce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcce_pkg::CFG_W-1:0]           cfg_data
);

  fcce_pkg::cfg_t cfg;
  fcce_pkg::req_t req;
  fcce_pkg::res_t res;
  logic core_ready;
  logic res_valid;
  logic res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_start_entry <= fcce_pkg::DATA_START_RESET;
      cfg.end_marker <= fcce_pkg::END_MARKER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        fcce_pkg::CFG_DATA_START: cfg.data_start_entry <= cfg_data;
        fcce_pkg::CFG_END_MARKER: cfg.end_marker <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign req.kind = kind;
  assign req.entry_index = entry_index;
  assign req.operand = operand;
  assign in_stall = !core_ready;
  assign res_ready = !out_valid || !out_stall;

  fcce_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid && core_ready),
    .req       (req),
    .cfg       (cfg),
    .ready     (core_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      answer <= res.answer;
      found <= res.found;
    end
  end

endmodule

// File: rtl/fcce_core.sv
`timescale 1ns / 1ps
// Sequencer and link table memory: clearing pass, entry writes, free scans and chain walks.
// Depends on fcce_pkg.
module fcce_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  fcce_pkg::req_t req,
  input  fcce_pkg::cfg_t cfg,
  output logic          ready,
  output logic          res_valid,
  output fcce_pkg::res_t res,
  input  logic          res_ready
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_CLEAR   = 6'b000010,
    ST_SCAN    = 6'b000100,
    ST_WALK_RD = 6'b001000,
    ST_WALK_EV = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  state_t state, state_next;
  fcce_pkg::kind_t kind, kind_next;
  logic [fcce_pkg::LINK_W-1:0] opnd, opnd_next;
  logic [fcce_pkg::LINK_W-1:0] cur, cur_next;
  logic [fcce_pkg::ANS_W-1:0] cnt, cnt_next;
  logic [fcce_pkg::ANS_W-1:0] scan_ptr, scan_ptr_next;
  logic pend, pend_next;
  logic [fcce_pkg::ANS_W-1:0] pend_idx, pend_idx_next;
  logic [fcce_pkg::IDX_W-1:0] clr_ptr, clr_ptr_next;
  fcce_pkg::res_t result, result_next;

  logic [fcce_pkg::LINK_W-1:0] mem [fcce_pkg::TABLE_ENTRIES];
  logic [fcce_pkg::LINK_W-1:0] rdata;
  logic mem_we;
  logic [fcce_pkg::IDX_W-1:0] mem_addr;
  logic [fcce_pkg::LINK_W-1:0] mem_wdata;

  logic issue;
  logic [fcce_pkg::ANS_W-1:0] cnt_inc;
  logic [fcce_pkg::LINK_W-1:0] link;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  assign cnt_inc = cnt + 1'b1;
  assign issue = (scan_ptr < fcce_pkg::ANS_W'(fcce_pkg::TABLE_ENTRIES));
  assign link = fcce_pkg::in_table(cur) ? rdata : '0;

  always_comb begin
    state_next = state;
    kind_next = kind;
    opnd_next = opnd;
    cur_next = cur;
    cnt_next = cnt;
    scan_ptr_next = scan_ptr;
    pend_next = pend;
    pend_idx_next = pend_idx;
    clr_ptr_next = clr_ptr;
    result_next = result;
    mem_we = 1'b0;
    mem_addr = cur[fcce_pkg::IDX_W-1:0];
    mem_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_ptr;
        clr_ptr_next = clr_ptr + 1'b1;
        if (clr_ptr == fcce_pkg::IDX_W'(fcce_pkg::TABLE_ENTRIES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          kind_next = fcce_pkg::kind_t'(req.kind);
          opnd_next = req.operand;
          cur_next = req.entry_index;
          cnt_next = '0;
          scan_ptr_next = {1'b0, cfg.data_start_entry};
          pend_next = 1'b0;
          result_next = '0;
          case (fcce_pkg::kind_t'(req.kind))
            fcce_pkg::KIND_FIND_FREE, fcce_pkg::KIND_COUNT_FREE: begin
              state_next = ST_SCAN;
            end
            fcce_pkg::KIND_WRITE_ENTRY: begin
              mem_we = fcce_pkg::in_table(req.entry_index);
              mem_addr = req.entry_index[fcce_pkg::IDX_W-1:0];
              mem_wdata = req.operand;
              state_next = ST_DONE;
            end
            fcce_pkg::KIND_FOLLOW_LINKS, fcce_pkg::KIND_FREE_CHAIN: begin
              state_next = ST_WALK_RD;
            end
            fcce_pkg::KIND_CHAIN_LENGTH: begin
              if (req.entry_index == '0) begin
                result_next.answer = {1'b0, cfg.data_start_entry};
                result_next.found = 1'b1;
                state_next = ST_DONE;
              end else begin
                cnt_next = fcce_pkg::ANS_W'(1);
                state_next = ST_WALK_RD;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        mem_addr = scan_ptr[fcce_pkg::IDX_W-1:0];
        if (issue) begin
          scan_ptr_next = scan_ptr + 1'b1;
        end
        pend_next = issue;
        pend_idx_next = scan_ptr;
        if (pend && (rdata == '0)) begin
          if (kind == fcce_pkg::KIND_FIND_FREE) begin
            result_next.answer = pend_idx;
            result_next.found = 1'b1;
            state_next = ST_DONE;
          end else begin
            cnt_next = cnt_inc;
            if ((opnd != '0) && (cnt_inc == {1'b0, opnd})) begin
              result_next.answer = cnt_inc;
              result_next.found = 1'b1;
              state_next = ST_DONE;
            end
          end
        end
        if (!pend && !issue) begin
          result_next.answer = (kind == fcce_pkg::KIND_FIND_FREE) ? '0 : cnt;
          result_next.found = 1'b0;
          state_next = ST_DONE;
        end
      end
      ST_WALK_RD: begin
        if ((kind == fcce_pkg::KIND_FOLLOW_LINKS) && (cnt == {1'b0, opnd})) begin
          result_next.answer = {1'b0, cur};
          result_next.found = 1'b1;
          state_next = ST_DONE;
        end else if ((kind == fcce_pkg::KIND_CHAIN_LENGTH) &&
                     (cnt == fcce_pkg::ANS_W'(fcce_pkg::TABLE_ENTRIES))) begin
          result_next.answer = cnt;
          result_next.found = 1'b0;
          state_next = ST_DONE;
        end else begin
          state_next = ST_WALK_EV;
        end
      end
      ST_WALK_EV: begin
        if (kind == fcce_pkg::KIND_FREE_CHAIN) begin
          mem_we = fcce_pkg::in_table(cur);
        end
        if (!fcce_pkg::link_continues(link, cfg.end_marker)) begin
          case (kind)
            fcce_pkg::KIND_FOLLOW_LINKS: begin
              result_next.answer = {1'b0, cur};
              result_next.found = 1'b0;
            end
            fcce_pkg::KIND_CHAIN_LENGTH: begin
              result_next.answer = cnt;
              result_next.found = 1'b1;
            end
            default: begin
              result_next = '0;
            end
          endcase
          state_next = ST_DONE;
        end else begin
          cur_next = link;
          cnt_next = cnt_inc;
          state_next = ST_WALK_RD;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_ptr <= '0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      clr_ptr <= clr_ptr_next;
      pend <= pend_next;
    end
    kind <= kind_next;
    opnd <= opnd_next;
    cur <= cur_next;
    cnt <= cnt_next;
    scan_ptr <= scan_ptr_next;
    pend_idx <= pend_idx_next;
    result <= result_next;
  end

  assign ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res = result;

endmodule

// File: rtl/fcce_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for fat_cluster_chain_engine and the bind that
// attaches them. Depends on fcce_pkg.
module fcce_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [fcce_pkg::ANS_W-1:0]     answer,
  input logic                           found
);

  // The table is being cleared right after reset, so no word may enter.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during the clearing pass");

  // Only one word is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a word was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(answer) && $stable(found)))
    else $error("output word changed while stalled");

endmodule

bind fat_cluster_chain_engine fcce_checker u_fcce_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of fat_cluster_chain_engine: directed tests, then random
// request mixes, each output word checked against a link table kept in the bench.
// Depends on rtl/fcce_pkg.sv and rtl/fat_cluster_chain_engine.sv.
module tb_top;

  localparam logic [fcce_pkg::KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [fcce_pkg::KIND_W-1:0] KIND_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT =
    3 * 200 * (2 * fcce_pkg::TABLE_ENTRIES + 40) + fcce_pkg::TABLE_ENTRIES;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [fcce_pkg::KIND_W-1:0] kind = '0;
  logic [fcce_pkg::LINK_W-1:0] entry_index = '0;
  logic [fcce_pkg::LINK_W-1:0] operand = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [fcce_pkg::ANS_W-1:0] answer;
  logic found;
  logic cfg_write = 1'b0;
  logic [fcce_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fcce_pkg::CFG_W-1:0] cfg_data = '0;

  logic [fcce_pkg::LINK_W-1:0] link_map [fcce_pkg::TABLE_ENTRIES] = '{default: '0};
  logic [fcce_pkg::LINK_W-1:0] model_start = fcce_pkg::DATA_START_RESET;
  logic [fcce_pkg::LINK_W-1:0] model_end_marker = fcce_pkg::END_MARKER_RESET;
  fcce_pkg::res_t answers_due[$];
  fcce_pkg::res_t expected_word;
  int chain_heads[$];
  int words_sent = 0;
  int words_checked = 0;
  int errors = 0;
  int loops_made = 0;
  int stall_left = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;

  fat_cluster_chain_engine dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit link_goes_on(input logic [fcce_pkg::LINK_W-1:0] v);
    return !(v == model_end_marker || v == '0 || v >= fcce_pkg::RESERVED_LINK_FLOOR);
  endfunction

  function automatic fcce_pkg::res_t fat_answer(input logic [fcce_pkg::KIND_W-1:0] k,
                                                input logic [fcce_pkg::LINK_W-1:0] idx,
                                                input logic [fcce_pkg::LINK_W-1:0] opd);
    fcce_pkg::res_t r;
    int i, cur, cnt;
    bit done;
    logic [fcce_pkg::LINK_W-1:0] nxt;
    r = '0;
    done = 1'b0;
    case (k)
      fcce_pkg::KIND_FIND_FREE: begin
        for (i = int'(model_start); i < fcce_pkg::TABLE_ENTRIES && !done; i++) begin
          if (link_map[i] == '0) begin
            r.answer = fcce_pkg::ANS_W'(i);
            r.found = 1'b1;
            done = 1'b1;
          end
        end
      end
      fcce_pkg::KIND_COUNT_FREE: begin
        cnt = 0;
        for (i = int'(model_start); i < fcce_pkg::TABLE_ENTRIES && !done; i++) begin
          if (link_map[i] == '0) begin
            cnt++;
            if (opd != '0 && cnt == int'(opd)) begin
              r.found = 1'b1;
              done = 1'b1;
            end
          end
        end
        r.answer = fcce_pkg::ANS_W'(cnt);
      end
      fcce_pkg::KIND_WRITE_ENTRY: link_map[idx] = opd;
      fcce_pkg::KIND_FOLLOW_LINKS: begin
        cur = int'(idx);
        cnt = 0;
        while (cnt < int'(opd) && !done) begin
          nxt = link_map[cur];
          if (link_goes_on(nxt)) begin
            cur = int'(nxt);
            cnt++;
          end else begin
            done = 1'b1;
          end
        end
        r.answer = fcce_pkg::ANS_W'(cur);
        r.found = (cnt == int'(opd));
      end
      fcce_pkg::KIND_CHAIN_LENGTH: begin
        if (idx == '0) begin
          r.answer = fcce_pkg::ANS_W'(model_start);
          r.found = 1'b1;
        end else begin
          // A cyclic chain gives up once the count reaches the table size.
          cur = int'(idx);
          cnt = 1;
          while (cnt < fcce_pkg::TABLE_ENTRIES && !done) begin
            nxt = link_map[cur];
            if (link_goes_on(nxt)) begin
              cur = int'(nxt);
              cnt++;
            end else begin
              r.found = 1'b1;
              done = 1'b1;
            end
          end
          r.answer = fcce_pkg::ANS_W'(cnt);
        end
      end
      fcce_pkg::KIND_FREE_CHAIN: begin
        cur = int'(idx);
        while (!done) begin
          nxt = link_map[cur];
          link_map[cur] = '0;
          if (link_goes_on(nxt)) cur = int'(nxt);
          else done = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [fcce_pkg::ANS_W-1:0] want,
                                 input logic [fcce_pkg::ANS_W-1:0] got);
    errors++;
    $display("%0t: word %0d: %s: expected %0d, got %0d", $time, words_checked, what,
             want, got);
  endtask

  task automatic send_request(input logic [fcce_pkg::KIND_W-1:0] k, input int idx,
                              input int opd);
    if (idle_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    entry_index <= fcce_pkg::LINK_W'(idx);
    operand <= fcce_pkg::LINK_W'(opd);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    answers_due.insert(answers_due.size(),
                       fat_answer(k, fcce_pkg::LINK_W'(idx), fcce_pkg::LINK_W'(opd)));
    words_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  task automatic set_config(input int start, input int endm);
    cfg_write <= 1'b1;
    cfg_index <= fcce_pkg::CFG_DATA_START;
    cfg_data <= fcce_pkg::CFG_W'(start);
    @(posedge clk);
    cfg_index <= fcce_pkg::CFG_END_MARKER;
    cfg_data <= fcce_pkg::CFG_W'(endm);
    @(posedge clk);
    cfg_write <= 1'b0;
    model_start = fcce_pkg::LINK_W'(start);
    model_end_marker = fcce_pkg::LINK_W'(endm);
  endtask

  function automatic int pick_entry();
    return ($urandom_range(0, 99) < 85) ? int'($urandom_range(3900, 4095))
                                        : int'($urandom_range(0, 4095));
  endfunction

  function automatic int choose_start();
    if (chain_heads.size() != 0 && $urandom_range(0, 99) < 80)
      return chain_heads[$urandom_range(0, chain_heads.size() - 1)];
    return int'($urandom_range(0, 4095));
  endfunction

  task automatic test_reset_state();
    send_request(fcce_pkg::KIND_FIND_FREE, 0, 0);
    send_request(fcce_pkg::KIND_COUNT_FREE, 4095, 0);
    send_request(fcce_pkg::KIND_CHAIN_LENGTH, 0, 4095);
    send_request(fcce_pkg::KIND_FOLLOW_LINKS, 5, 3);
  endtask

  task automatic test_register_extremes();
    wait_for_drain();
    set_config(0, 0);
    send_request(fcce_pkg::KIND_COUNT_FREE, 0, 0);
    send_request(fcce_pkg::KIND_FIND_FREE, 4095, 4095);
    wait_for_drain();
    set_config(4095, 4095);
    send_request(fcce_pkg::KIND_WRITE_ENTRY, 4095, 12'hFFF);
    send_request(fcce_pkg::KIND_FIND_FREE, 0, 0);
    send_request(fcce_pkg::KIND_COUNT_FREE, 0, 4095);
  endtask

  task automatic test_chain_walks();
    wait_for_drain();
    set_config(4000, 12'h7A0);
    send_request(fcce_pkg::KIND_WRITE_ENTRY, 4001, 4005);
    // A link just below the reserved range still continues the chain.
    send_request(fcce_pkg::KIND_WRITE_ENTRY, 4005, 12'hFEF);
    send_request(fcce_pkg::KIND_WRITE_ENTRY, 12'hFEF, 12'h7A0);
    send_request(fcce_pkg::KIND_CHAIN_LENGTH, 4001, 0);
    send_request(fcce_pkg::KIND_FOLLOW_LINKS, 4001, 2);
    send_request(fcce_pkg::KIND_FOLLOW_LINKS, 4001, 5);
    send_request(fcce_pkg::KIND_WRITE_ENTRY, 4002, fcce_pkg::RESERVED_LINK_FLOOR);
    send_request(fcce_pkg::KIND_CHAIN_LENGTH, 4002, 0);
    send_request(fcce_pkg::KIND_FREE_CHAIN, 4001, 0);
    send_request(fcce_pkg::KIND_CHAIN_LENGTH, 4005, 0);
  endtask

  task automatic test_cyclic_chain();
    send_request(fcce_pkg::KIND_WRITE_ENTRY, 4090, 4091);
    send_request(fcce_pkg::KIND_WRITE_ENTRY, 4091, 4090);
    send_request(fcce_pkg::KIND_CHAIN_LENGTH, 4090, 0);
    send_request(fcce_pkg::KIND_FOLLOW_LINKS, 4090, 4095);
    send_request(fcce_pkg::KIND_FREE_CHAIN, 4090, 0);
  endtask

  task automatic test_spare_kinds();
    send_request(KIND_SPARE_6, $urandom_range(0, 4095), $urandom_range(0, 4095));
    send_request(KIND_SPARE_7, $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  task automatic test_random_mix(input int n, input int start, input int endm);
    int target, r, len, j, m, pick;
    int nodes[5];
    bit dup;
    logic [fcce_pkg::LINK_W-1:0] tail;
    wait_for_drain();
    set_config(start, endm);
    target = words_sent + n;
    while (words_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        len = $urandom_range(1, 5);
        for (j = 0; j < len; j++) begin
          do begin
            nodes[j] = pick_entry();
            dup = 1'b0;
            for (m = 0; m < j; m++) if (nodes[m] == nodes[j]) dup = 1'b1;
          end while (dup);
        end
        for (j = 0; j + 1 < len; j++)
          send_request(fcce_pkg::KIND_WRITE_ENTRY, nodes[j], nodes[j + 1]);
        if (loops_made < 3 && $urandom_range(0, 99) < 8) begin
          loops_made++;
          tail = fcce_pkg::LINK_W'(nodes[0]);
        end else begin
          case ($urandom_range(0, 2))
            0: tail = model_end_marker;
            1: tail = fcce_pkg::LINK_W'($urandom_range(fcce_pkg::RESERVED_LINK_FLOOR,
                                                       12'hFFF));
            default: tail = '0;
          endcase
        end
        send_request(fcce_pkg::KIND_WRITE_ENTRY, nodes[len - 1], tail);
        chain_heads.insert(chain_heads.size(), nodes[0]);
      end else if (r < 45) begin
        send_request(fcce_pkg::KIND_FOLLOW_LINKS, choose_start(),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 6));
      end else if (r < 58) begin
        send_request(fcce_pkg::KIND_CHAIN_LENGTH,
                     ($urandom_range(0, 9) == 0) ? 0 : choose_start(),
                     $urandom_range(0, 4095));
      end else if (r < 66) begin
        if (chain_heads.size() != 0) begin
          pick = $urandom_range(0, chain_heads.size() - 1);
          send_request(fcce_pkg::KIND_FREE_CHAIN, chain_heads[pick],
                       $urandom_range(0, 4095));
          chain_heads.delete(pick);
        end else begin
          send_request(fcce_pkg::KIND_FREE_CHAIN, $urandom_range(0, 4095),
                       $urandom_range(0, 4095));
        end
      end else if (r < 76) begin
        send_request(fcce_pkg::KIND_FIND_FREE, $urandom_range(0, 4095),
                     $urandom_range(0, 4095));
      end else if (r < 86) begin
        m = $urandom_range(0, 9);
        send_request(fcce_pkg::KIND_COUNT_FREE, $urandom_range(0, 4095),
                     (m < 3) ? 0 : (m == 9) ? $urandom_range(0, 4095) : $urandom_range(1, 40));
      end else if (r < 92) begin
        send_request(fcce_pkg::KIND_WRITE_ENTRY, $urandom_range(0, 4095),
                     $urandom_range(0, 4095));
      end else if (r < 96) begin
        send_request($urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7,
                     $urandom_range(0, 4095), $urandom_range(0, 4095));
      end else begin
        wait_for_drain();
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 99) < 12) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      words_checked++;
      if (answers_due.size() == 0) begin
        report_mismatch("word with nothing expected", '0, answer);
      end else begin
        expected_word = answers_due.pop_front();
        if (answer !== expected_word.answer)
          report_mismatch("answer", expected_word.answer, answer);
        if (found !== expected_word.found)
          report_mismatch("found", fcce_pkg::ANS_W'(expected_word.found),
                          fcce_pkg::ANS_W'(found));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_register_extremes();
    test_chain_walks();
    test_cyclic_chain();
    test_spare_kinds();
    test_random_mix(30, 4032, 4095);
    test_random_mix(20, 14, 4095);
    test_random_mix(24, 3968, 0);
    test_random_mix(20, 4064, $urandom_range(0, 4095));
    idle_on = 1'b0;
    test_random_mix(20, 4080, 12'h0F5);
    wait_for_drain();
    repeat (16) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: fat_cluster_chain_engine.f
rtl/fcce_pkg.sv
rtl/fcce_core.sv
rtl/fat_cluster_chain_engine.sv
rtl/fcce_checker.sv
tb/tb_top.sv
